// ===== rtl/apn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package apn_pkg;

  localparam logic [7:0] SLASH = 8'h2F;
  localparam logic [7:0] DOT   = 8'h2E;

  localparam int StoreDepth = 256;
  localparam logic [8:0] STORE_DEPTH = 9'd256;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_APPEND = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_DOT    = 2'd1,
    CLS_DOTDOT = 2'd2,
    CLS_NAME   = 2'd3
  } cls_t;

endpackage
`default_nettype wire

// ===== rtl/apn_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface apn_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] ch;
  logic       last;
  logic [7:0] read_index;

  modport source (output valid, op, ch, last, read_index, input ready);
  modport sink (input valid, op, ch, last, read_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/apn_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface apn_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic       status;
  logic [7:0] out_len;
  logic [7:0] out_byte;

  modport source (output valid, kind, status, out_len, out_byte, input ready);
  modport sink (input valid, kind, status, out_len, out_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/absolute_path_normalizer_unit.sv =====
// Channel   Dir  Word
// in_chan   in   op, ch, last, read_index
// out_chan  out  kind, status, out_len, out_byte
//
// A read word is accepted, then answered from the registered store read. A path
// character is accepted, then handled, and an append step follows when a name opens
// behind a kept part, since the separator slash and the character go through one write
// port. Reset is synchronous; the stores need no clearing pass, and byte zero reads as
// a slash while the length is nonzero. A new word is accepted while a result waits;
// the block stalls only when its next result finds the output register still full.
`timescale 1ns / 1ps
`default_nettype none
module absolute_path_normalizer_unit #(
  parameter int PATH_MAX_BYTES = 256,
  parameter int MAX_PARTS      = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  apn_in_if.sink    in_chan,
  apn_out_if.source out_chan
);
  import apn_pkg::*;

  localparam int ICW = $clog2(PATH_MAX_BYTES + 1);
  localparam int KW  = $clog2(MAX_PARTS + 1);
  localparam int SW  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam logic [ICW-1:0] PMAX = ICW'(PATH_MAX_BYTES);
  localparam logic [KW-1:0]  KMAX = KW'(MAX_PARTS);

  state_t         state_r, state_nxt;
  logic [8:0]     ol_r, ol_nxt;
  logic [KW-1:0]  kp_r, kp_nxt;
  cls_t           cls_r, cls_nxt;
  logic [8:0]     os_r, os_nxt;
  logic           err_r, err_nxt;
  logic [ICW-1:0] ic_r, ic_nxt;

  logic       op_r, last_r;
  logic [7:0] ch_r, idx_r;

  logic [7:0] store_mem [StoreDepth];
  logic [7:0] store_q_r;
  logic       store_we;
  logic [7:0] store_wa, store_wd;

  logic [7:0] stk_mem [MAX_PARTS];
  logic [7:0] stk_q_r;
  logic       stk_we;
  logic [SW-1:0] stk_wa;
  logic [7:0] stk_wd;
  logic [KW-1:0] kp_dec;

  logic       out_valid_r, out_kind_r, out_status_r;
  logic [7:0] out_len_r, out_byte_r;

  logic       emit, e_kind, e_status;
  logic [7:0] e_len, e_byte;
  logic       app_c, need2, fin, close_req;
  logic       accept, slot_free, go;

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign slot_free     = !out_valid_r || out_chan.ready;
  assign go            = !emit || slot_free;
  assign kp_dec        = kp_r - KW'(1);

  assign out_chan.valid    = out_valid_r;
  assign out_chan.kind     = out_kind_r;
  assign out_chan.status   = out_status_r;
  assign out_chan.out_len  = out_len_r;
  assign out_chan.out_byte = out_byte_r;

  always_comb begin
    state_nxt = state_r;
    ol_nxt    = ol_r;
    kp_nxt    = kp_r;
    cls_nxt   = cls_r;
    os_nxt    = os_r;
    err_nxt   = err_r;
    ic_nxt    = ic_r;
    store_we  = 1'b0;
    store_wa  = '0;
    store_wd  = '0;
    stk_we    = 1'b0;
    stk_wa    = '0;
    stk_wd    = '0;
    emit      = 1'b0;
    e_kind    = KIND_STATUS;
    e_status  = STATUS_OK;
    e_len     = '0;
    e_byte    = '0;
    app_c     = 1'b0;
    need2     = 1'b0;
    fin       = 1'b0;
    close_req = 1'b0;

    case (state_r)
      S_EXEC: begin
        if (op_r == OP_READ) begin
          emit      = 1'b1;
          e_kind    = KIND_DATA;
          if ({1'b0, idx_r} < ol_r) begin
            e_byte = (idx_r == 8'd0) ? SLASH : store_q_r;
          end
          state_nxt = S_IDLE;
        end else begin
          if (ic_r == '0) begin
            ol_nxt  = 9'd1;
            kp_nxt  = '0;
            cls_nxt = CLS_NONE;
            os_nxt  = '0;
            err_nxt = (ch_r != SLASH);
          end
          if (ic_nxt < PMAX) begin
            ic_nxt = ic_nxt + ICW'(1);
          end
          if (ic_nxt >= PMAX) begin
            err_nxt = 1'b1;
          end
          if (!err_nxt) begin
            if (ch_r == SLASH) begin
              close_req = 1'b1;
            end else begin
              case (cls_nxt)
                CLS_NONE: begin
                  os_nxt  = ol_nxt;
                  cls_nxt = (ch_r == DOT) ? CLS_DOT : CLS_NAME;
                  if (ol_nxt > 9'd1) begin
                    if (ol_nxt >= STORE_DEPTH) begin
                      err_nxt = 1'b1;
                    end else begin
                      store_we = 1'b1;
                      store_wa = ol_nxt[7:0];
                      store_wd = SLASH;
                      ol_nxt   = ol_nxt + 9'd1;
                      need2    = 1'b1;
                    end
                  end else begin
                    app_c = 1'b1;
                  end
                end
                CLS_DOT: begin
                  cls_nxt = (ch_r == DOT) ? CLS_DOTDOT : CLS_NAME;
                  app_c   = 1'b1;
                end
                default: begin
                  cls_nxt = CLS_NAME;
                  app_c   = 1'b1;
                end
              endcase
            end
          end
          fin       = last_r && !need2;
          state_nxt = need2 ? S_APPEND : S_IDLE;
        end
      end
      S_APPEND: begin
        app_c     = 1'b1;
        fin       = last_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = accept ? S_EXEC : S_IDLE;
      end
    endcase

    if (app_c) begin
      if (ol_nxt >= STORE_DEPTH) begin
        err_nxt = 1'b1;
      end else begin
        store_we = 1'b1;
        store_wa = ol_nxt[7:0];
        store_wd = ch_r;
        ol_nxt   = ol_nxt + 9'd1;
      end
    end

    if (!err_nxt && (close_req || fin)) begin
      case (cls_nxt)
        CLS_DOT: begin
          ol_nxt = os_nxt;
        end
        CLS_DOTDOT: begin
          ol_nxt = os_nxt;
          if (kp_nxt != '0) begin
            kp_nxt = kp_nxt - KW'(1);
            ol_nxt = {1'b0, stk_q_r};
          end
        end
        CLS_NAME: begin
          if (kp_nxt >= KMAX) begin
            err_nxt = 1'b1;
          end else begin
            stk_we = 1'b1;
            stk_wa = kp_nxt[SW-1:0];
            stk_wd = os_nxt[7:0];
            kp_nxt = kp_nxt + KW'(1);
          end
        end
        default: begin
        end
      endcase
      cls_nxt = CLS_NONE;
    end

    if (fin) begin
      emit     = 1'b1;
      e_kind   = KIND_STATUS;
      e_status = err_nxt ? STATUS_ERR : STATUS_OK;
      e_len    = err_nxt ? 8'd0 : ol_nxt[7:0];
      ol_nxt   = err_nxt ? 9'd0 : ol_nxt;
      ic_nxt   = '0;
      cls_nxt  = CLS_NONE;
      err_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ol_r        <= 9'd1;
      kp_r        <= '0;
      cls_r       <= CLS_NONE;
      os_r        <= '0;
      err_r       <= 1'b0;
      ic_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_IDLE) begin
        state_r <= state_nxt;
      end else if (go) begin
        state_r <= state_nxt;
        ol_r    <= ol_nxt;
        kp_r    <= kp_nxt;
        cls_r   <= cls_nxt;
        os_r    <= os_nxt;
        err_r   <= err_nxt;
        ic_r    <= ic_nxt;
      end
      if (emit && go) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_chan.op;
      ch_r   <= in_chan.ch;
      last_r <= in_chan.last;
      idx_r  <= in_chan.read_index;
    end
    if (emit && go) begin
      out_kind_r   <= e_kind;
      out_status_r <= e_status;
      out_len_r    <= e_len;
      out_byte_r   <= e_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we && go) begin
      store_mem[store_wa] <= store_wd;
    end
    if (accept) begin
      store_q_r <= store_mem[in_chan.read_index];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we && go) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (accept) begin
      stk_q_r <= stk_mem[kp_dec[SW-1:0]];
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ol_r <= STORE_DEPTH)
    else $error("output length beyond store depth");

  a_parts_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kp_r <= KMAX)
    else $error("kept part count beyond limit");

  a_append_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPEND) |-> $past(state_r) != S_IDLE)
    else $error("second append step without a character step");

  a_no_root_write: assert property (@(posedge clk) disable iff (!rst_n)
    (store_we && go) |-> store_wa != 8'd0)
    else $error("write to the root slash position");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) != S_IDLE)
    else $error("result raised without a word in work");

endmodule
`default_nettype wire

// ===== tb/sv/absolute_path_normalizer_unit_tb.sv =====
`timescale 1ns / 1ps
module absolute_path_normalizer_unit_tb;
  import apn_pkg::*;

  localparam int PATH_LIMIT = 256;
  localparam int PART_LIMIT = 64;
  localparam int WORD_TARGET = 1350;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_AFTER = 200;
  localparam int HOLD_CYCLES = 250;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
    logic       last;
    logic [7:0] read_index;
  } path_word_t;

  typedef struct packed {
    logic       kind;
    logic       status;
    logic [7:0] out_len;
    logic [7:0] out_byte;
  } norm_result_t;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
    logic       last;
    logic [7:0] read_index;
    logic       typed_in;
    logic       kind;
    logic       status;
    logic [7:0] out_len;
    logic [7:0] out_byte;
  } dir_row_t;

  typedef logic [7:0] char_q_t[$];

  logic clk;
  logic rst_n;

  apn_in_if in_chan ();
  apn_out_if out_chan ();

  absolute_path_normalizer_unit #(
    .PATH_MAX_BYTES(PATH_LIMIT),
    .MAX_PARTS(PART_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  logic [7:0] norm_bytes [256];
  logic [7:0] part_marks [128];
  logic [8:0] norm_len;
  logic [6:0] part_count;
  logic [8:0] char_count;
  logic [8:0] comp_start;
  cls_t       comp_cls;
  logic       path_bad;

  norm_result_t pending_results[$];
  char_q_t      path_chars;
  norm_result_t got;
  norm_result_t want;

  int unsigned mismatches;
  int unsigned words_accepted;
  int unsigned counted_words;
  int unsigned cycle_count;
  bit steady_in;
  bit steady_out;
  bit hold_done;

  dir_row_t directed_rows [24] = '{
    '{OP_READ, 8'h00, 1'b0, 8'd0,   1'b1, KIND_DATA,   STATUS_OK,  8'd0, SLASH},
    '{OP_READ, 8'h5A, 1'b0, 8'd255, 1'b1, KIND_DATA,   STATUS_OK,  8'd0, 8'd0},
    '{OP_READ, 8'hA5, 1'b1, 8'd1,   1'b1, KIND_DATA,   STATUS_OK,  8'd0, 8'd0},
    '{OP_CHAR, SLASH, 1'b1, 8'd0,   1'b1, KIND_STATUS, STATUS_OK,  8'd1, 8'd0},
    '{OP_CHAR, "x",   1'b1, 8'd0,   1'b1, KIND_STATUS, STATUS_ERR, 8'd0, 8'd0},
    '{OP_READ, 8'h00, 1'b0, 8'd0,   1'b1, KIND_DATA,   STATUS_OK,  8'd0, 8'd0},
    '{OP_CHAR, SLASH, 1'b0, 8'd0,   1'b0, KIND_STATUS, STATUS_OK,  8'd0, 8'd0},
    '{OP_CHAR, SLASH, 1'b0, 8'd0,   1'b0, KIND_STATUS, STATUS_OK,  8'd0, 8'd0},
    '{OP_CHAR, DOT,   1'b0, 8'd0,   1'b0, KIND_STATUS, STATUS_OK,  8'd0, 8'd0},
    '{OP_CHAR, DOT,   1'b0, 8'd0,   1'b0, KIND_STATUS, STATUS_OK,  8'd0, 8'd0},
    '{OP_CHAR, SLASH, 1'b0, 8'd0,   1'b0, KIND_STATUS, STATUS_OK,  8'd0, 8'd0},
    '{OP_CHAR, DOT,   1'b0, 8'd0,   1'b0, KIND_STATUS, STATUS_OK,  8'd0, 8'd0},
    '{OP_CHAR, SLASH, 1'b0, 8'd0,   1'b0, KIND_STATUS, STATUS_OK,  8'd0, 8'd0},
    '{OP_CHAR, "b",   1'b0, 8'd0,   1'b0, KIND_STATUS, STATUS_OK,  8'd0, 8'd0},
    '{OP_CHAR, 8'h00, 1'b0, 8'hFF,  1'b0, KIND_STATUS, STATUS_OK,  8'd0, 8'd0},
    '{OP_CHAR, 8'hFF, 1'b0, 8'd0,   1'b0, KIND_STATUS, STATUS_OK,  8'd0, 8'd0},
    '{OP_CHAR, SLASH, 1'b0, 8'd0,   1'b0, KIND_STATUS, STATUS_OK,  8'd0, 8'd0},
    '{OP_CHAR, "c",   1'b0, 8'd0,   1'b0, KIND_STATUS, STATUS_OK,  8'd0, 8'd0},
    '{OP_READ, 8'h00, 1'b0, 8'd5,   1'b0, KIND_DATA,   STATUS_OK,  8'd0, 8'd0},
    '{OP_CHAR, SLASH, 1'b0, 8'd0,   1'b0, KIND_STATUS, STATUS_OK,  8'd0, 8'd0},
    '{OP_CHAR, DOT,   1'b0, 8'd0,   1'b0, KIND_STATUS, STATUS_OK,  8'd0, 8'd0},
    '{OP_CHAR, DOT,   1'b1, 8'd0,   1'b1, KIND_STATUS, STATUS_OK,  8'd4, 8'd0},
    '{OP_READ, 8'h00, 1'b0, 8'd3,   1'b0, KIND_DATA,   STATUS_OK,  8'd0, 8'd0},
    '{OP_READ, 8'h00, 1'b0, 8'd4,   1'b0, KIND_DATA,   STATUS_OK,  8'd0, 8'd0}
  };

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void clear_normalizer();
    norm_bytes[0] = SLASH;
    norm_len = 9'd1;
    part_count = '0;
    char_count = '0;
    comp_start = '0;
    comp_cls = CLS_NONE;
    path_bad = 1'b0;
  endfunction

  function automatic void append_char(input logic [7:0] b);
    if (norm_len >= STORE_DEPTH) begin
      path_bad = 1'b1;
    end else begin
      norm_bytes[norm_len[7:0]] = b;
      norm_len = norm_len + 9'd1;
    end
  endfunction

  function automatic void end_part();
    case (comp_cls)
      CLS_DOT: begin
        norm_len = comp_start;
      end
      CLS_DOTDOT: begin
        norm_len = comp_start;
        if (part_count != '0) begin
          part_count = part_count - 7'd1;
          norm_len = {1'b0, part_marks[part_count]};
        end
      end
      CLS_NAME: begin
        if (part_count >= 7'(PART_LIMIT)) begin
          path_bad = 1'b1;
        end else begin
          part_marks[part_count] = comp_start[7:0];
          part_count = part_count + 7'd1;
        end
      end
      default: begin
      end
    endcase
    comp_cls = CLS_NONE;
  endfunction

  function automatic void absorb_char(input logic [7:0] c);
    if (char_count == '0) begin
      norm_bytes[0] = SLASH;
      norm_len = 9'd1;
      part_count = '0;
      comp_cls = CLS_NONE;
      comp_start = '0;
      path_bad = (c != SLASH);
    end
    if (char_count < 9'(PATH_LIMIT)) char_count = char_count + 9'd1;
    if (char_count >= 9'(PATH_LIMIT)) path_bad = 1'b1;
    if (path_bad) return;
    if (c == SLASH) begin
      end_part();
      return;
    end
    case (comp_cls)
      CLS_NONE: begin
        comp_start = norm_len;
        if (norm_len > 9'd1) append_char(SLASH);
        comp_cls = (c == DOT) ? CLS_DOT : CLS_NAME;
      end
      CLS_DOT: begin
        comp_cls = (c == DOT) ? CLS_DOTDOT : CLS_NAME;
      end
      default: begin
        comp_cls = CLS_NAME;
      end
    endcase
    if (!path_bad) append_char(c);
  endfunction

  function automatic bit normalize_word(input path_word_t w, output norm_result_t r);
    r = '0;
    if (w.op == OP_READ) begin
      r.kind = KIND_DATA;
      r.status = STATUS_OK;
      if ({1'b0, w.read_index} < norm_len) r.out_byte = norm_bytes[w.read_index];
      return 1'b1;
    end
    absorb_char(w.ch);
    if (!w.last) return 1'b0;
    if (!path_bad) end_part();
    r.kind = KIND_STATUS;
    if (path_bad) begin
      r.status = STATUS_ERR;
      norm_len = '0;
    end else begin
      r.status = STATUS_OK;
      r.out_len = norm_len[7:0];
    end
    char_count = '0;
    comp_cls = CLS_NONE;
    path_bad = 1'b0;
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] other_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 254));
    if (c >= SLASH) c = c + 8'd1;
    return c;
  endfunction

  function automatic logic [7:0] letter();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] name_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return letter();
    if (r < 85) return DOT;
    return other_char();
  endfunction

  function automatic logic [7:0] pick_index();
    int unsigned hi;
    hi = int'(norm_len) + 1;
    if (hi > 255) hi = 255;
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, hi));
  endfunction

  function automatic void add_component();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      path_chars.push_back(DOT);
    end else if (r < 4) begin
      path_chars.push_back(DOT);
      path_chars.push_back(DOT);
    end else begin
      repeat ($urandom_range(1, 4)) path_chars.push_back(name_char());
    end
  endfunction

  function automatic void build_normal(input bit absolute);
    int unsigned parts;
    int unsigned k;
    path_chars.delete();
    path_chars.push_back(absolute ? SLASH : other_char());
    if ($urandom_range(0, 3) == 0) path_chars.push_back(SLASH);
    parts = $urandom_range(0, 6);
    for (k = 0; k < parts; k++) begin
      add_component();
      if (k + 1 < parts) begin
        repeat ($urandom_range(1, 3)) path_chars.push_back(SLASH);
      end else begin
        repeat ($urandom_range(0, 2)) path_chars.push_back(SLASH);
      end
    end
  endfunction

  function automatic void build_deep(input int unsigned names, input bit with_ups);
    int unsigned k;
    path_chars.delete();
    path_chars.push_back(SLASH);
    for (k = 0; k < names; k++) begin
      if (with_ups && $urandom_range(0, 19) == 0) begin
        path_chars.push_back(DOT);
        path_chars.push_back(DOT);
        path_chars.push_back(SLASH);
      end
      path_chars.push_back(letter());
      if (k + 1 < names) path_chars.push_back(SLASH);
    end
  endfunction

  function automatic void build_long(input int unsigned length);
    path_chars.delete();
    path_chars.push_back(SLASH);
    while (path_chars.size() < length) begin
      if (path_chars.size() > 1 && $urandom_range(0, 9) == 0) begin
        path_chars.push_back(SLASH);
      end else begin
        path_chars.push_back(name_char());
      end
    end
  endfunction

  function automatic void build_noise();
    path_chars.delete();
    repeat ($urandom_range(1, 8)) path_chars.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic send_word(input path_word_t w, input bit typed_in,
                           input norm_result_t typed_r);
    int unsigned gap;
    norm_result_t r;
    bit has_r;
    gap = pick_gap(steady_in);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.op <= w.op;
    in_chan.ch <= w.ch;
    in_chan.last <= w.last;
    in_chan.read_index <= w.read_index;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    words_accepted++;
    if (w.op == OP_READ || !path_bad) counted_words++;
    has_r = normalize_word(w, r);
    if (has_r) pending_results.push_back(typed_in ? typed_r : r);
    @(negedge clk);
  endtask

  task automatic send_read(input logic [7:0] idx);
    path_word_t w;
    w.op = OP_READ;
    w.ch = 8'($urandom_range(0, 255));
    w.last = 1'($urandom_range(0, 1));
    w.read_index = idx;
    send_word(w, 1'b0, '0);
  endtask

  task automatic send_path();
    path_word_t w;
    int unsigned i;
    for (i = 0; i < path_chars.size(); i++) begin
      if ($urandom_range(0, 15) == 0) send_read(pick_index());
      w.op = OP_CHAR;
      w.ch = path_chars[i];
      w.last = (i + 1 == path_chars.size());
      w.read_index = 8'($urandom_range(0, 255));
      send_word(w, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.kind, out_chan.status, out_chan.out_len, out_chan.out_byte};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word with none pending, kind %0d", got.kind));
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
        if (got.out_len !== want.out_len)
          report_mismatch($sformatf("out_len %0d, wanted %0d", got.out_len, want.out_len));
        if (got.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, wanted %02h", got.out_byte, want.out_byte));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("absolute_path_normalizer_unit_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned run;
    int unsigned gap;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!hold_done && words_accepted >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      run = $urandom_range(1, 24);
      out_chan.ready <= 1'b1;
      repeat (run) @(negedge clk);
      if ($urandom_range(0, 7) == 0) steady_out = ~steady_out;
      gap = pick_gap(steady_out);
      if (gap != 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin
    path_word_t w;
    norm_result_t r;
    int unsigned path_no;
    int unsigned pick;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.op = OP_CHAR;
    in_chan.ch = 8'd0;
    in_chan.last = 1'b0;
    in_chan.read_index = 8'd0;
    clear_normalizer();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      w = '{directed_rows[i].op, directed_rows[i].ch, directed_rows[i].last,
            directed_rows[i].read_index};
      r = '{directed_rows[i].kind, directed_rows[i].status, directed_rows[i].out_len,
            directed_rows[i].out_byte};
      send_word(w, directed_rows[i].typed_in, r);
    end

    // The first paths sit on the length and part-count limits from both sides.
    path_no = 0;
    while (counted_words < WORD_TARGET) begin
      case (path_no)
        0: build_long(PATH_LIMIT - 1);
        1: build_long(PATH_LIMIT);
        2: build_deep(PART_LIMIT, 1'b0);
        3: build_deep(PART_LIMIT + 1, 1'b0);
        default: begin
          pick = $urandom_range(0, 99);
          if (pick < 84) build_normal(1'b1);
          else if (pick < 89) build_normal(1'b0);
          else if (pick < 94) build_noise();
          else if (pick < 97) build_deep($urandom_range(58, 70), 1'b1);
          else build_long($urandom_range(240, 265));
        end
      endcase
      if ($urandom_range(0, 6) == 0) steady_in = ~steady_in;
      send_path();
      repeat ($urandom_range(0, 3)) send_read(pick_index());
      path_no++;
    end
    in_chan.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("absolute_path_normalizer_unit_tb: done, clean");
    end else begin
      $display("absolute_path_normalizer_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/apn_pkg.sv
rtl/apn_in_if.sv
rtl/apn_out_if.sv
rtl/absolute_path_normalizer_unit.sv
tb/sv/absolute_path_normalizer_unit_tb.sv
